// ===== rtl/sirc_enc_pkg.sv =====
// Shared types and constants for the SIRC infrared frame encoder.
package sirc_enc_pkg;

  localparam int unsigned CmdInW   = 24;
  localparam int unsigned LenW     = 8;
  localparam int unsigned BitCntW  = 5;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned CmdWidthDefault = 24;

  localparam logic [LenW-1:0] StartMarkReset = 8'd96;
  localparam logic [LenW-1:0] OneMarkReset   = 8'd48;
  localparam logic [LenW-1:0] ZeroMarkReset  = 8'd24;
  localparam logic [LenW-1:0] SpaceReset     = 8'd24;
  localparam logic [LenW-1:0] PauseReset     = 8'd45;

  localparam logic [BitCntW-1:0] Bits20 = 5'd20;
  localparam logic [BitCntW-1:0] Bits15 = 5'd15;
  localparam logic [BitCntW-1:0] Bits12 = 5'd12;

  localparam int unsigned Flag20Bit = 23;
  localparam int unsigned Flag15Bit = 15;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SEND   = 2'd1,
    OP_REPEAT = 2'd2,
    OP_STOP   = 2'd3
  } opcode_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_START_MARK = 3'd0,
    REG_ONE_MARK   = 3'd1,
    REG_ZERO_MARK  = 3'd2,
    REG_SPACE      = 3'd3,
    REG_PAUSE      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LenW-1:0] start_mark_len;
    logic [LenW-1:0] one_mark_len;
    logic [LenW-1:0] zero_mark_len;
    logic [LenW-1:0] space_len;
    logic [LenW-1:0] pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic            busy_res;
    logic            interval_valid;
    logic [LenW-1:0] interval_len;
    logic            carrier_on;
  } result_t;

endpackage

// ===== rtl/sirc_enc_cfg.sv =====
// Configuration register bank for the SIRC encoder.
module sirc_enc_cfg
  import sirc_enc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [LenW-1:0]     cfg_wdata,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_mark_len <= StartMarkReset;
      cfg.one_mark_len   <= OneMarkReset;
      cfg.zero_mark_len  <= ZeroMarkReset;
      cfg.space_len      <= SpaceReset;
      cfg.pause_ticks    <= PauseReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_MARK: cfg.start_mark_len <= cfg_wdata;
        REG_ONE_MARK:   cfg.one_mark_len   <= cfg_wdata;
        REG_ZERO_MARK:  cfg.zero_mark_len  <= cfg_wdata;
        REG_SPACE:      cfg.space_len      <= cfg_wdata;
        REG_PAUSE:      cfg.pause_ticks    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/sirc_enc_core.sv =====
// Frame sequencer: phase state, command storage and per-item result logic.
module sirc_enc_core
  import sirc_enc_pkg::*;
#(
  parameter int unsigned CMD_WIDTH = CmdWidthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        opcode,
  input  logic [CmdInW-1:0] command_word,
  input  cfg_t              cfg,
  output result_t           result
);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_MARK  = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_PAUSE       = 3'd5
  } phase_t;

  phase_t                 phase, phase_next;
  logic [CMD_WIDTH-1:0]   shift_word, shift_word_next;
  logic [CMD_WIDTH-1:0]   active_command, active_command_next;
  logic [BitCntW-1:0]     bits_in_frame, bits_in_frame_next;
  logic [BitCntW-1:0]     frame_bits_latched, frame_bits_latched_next;
  logic [BitCntW-1:0]     bit_count, bit_count_next;
  logic [LenW-1:0]        pause_count, pause_count_next;

  logic [CMD_WIDTH+CmdInW-1:0] word_ext;
  logic [BitCntW-1:0]          bit_count_inc;
  logic [LenW-1:0]             pause_count_inc;
  opcode_t                     op;

  assign op              = opcode_t'(opcode);
  assign word_ext        = {{CMD_WIDTH{1'b0}}, command_word};
  assign bit_count_inc   = bit_count + BitCntW'(1);
  assign pause_count_inc = pause_count + LenW'(1);

  always_comb begin
    phase_next              = phase;
    shift_word_next         = shift_word;
    active_command_next     = active_command;
    bits_in_frame_next      = bits_in_frame;
    frame_bits_latched_next = frame_bits_latched;
    bit_count_next          = bit_count;
    pause_count_next        = pause_count;
    result                  = '0;

    unique case (op)
      OP_TICK: begin
        unique case (phase)
          PH_START_MARK: begin
            result.carrier_on     = 1'b1;
            result.interval_len   = cfg.start_mark_len;
            result.interval_valid = 1'b1;
            phase_next            = PH_START_SPACE;
          end
          PH_START_SPACE: begin
            result.interval_len   = cfg.space_len;
            result.interval_valid = 1'b1;
            phase_next            = PH_BIT_MARK;
          end
          PH_BIT_MARK: begin
            result.carrier_on     = 1'b1;
            result.interval_valid = 1'b1;
            result.interval_len   = shift_word[0] ? cfg.one_mark_len : cfg.zero_mark_len;
            shift_word_next       = shift_word >> 1;
            phase_next            = PH_BIT_SPACE;
          end
          PH_BIT_SPACE: begin
            result.interval_len   = cfg.space_len;
            result.interval_valid = 1'b1;
            bit_count_next        = bit_count_inc;
            phase_next = (bit_count_inc == frame_bits_latched) ? PH_PAUSE : PH_BIT_MARK;
          end
          PH_PAUSE: begin
            result.interval_len   = cfg.space_len;
            result.interval_valid = 1'b1;
            pause_count_next      = pause_count_inc;
            if (pause_count_inc >= cfg.pause_ticks) begin
              bit_count_next   = '0;
              pause_count_next = '0;
              phase_next       = PH_IDLE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      OP_SEND, OP_REPEAT: begin
        if (op == OP_SEND) begin
          active_command_next = word_ext[CMD_WIDTH-1:0];
          if (command_word[Flag20Bit]) begin
            bits_in_frame_next = Bits20;
          end else if (command_word[Flag15Bit]) begin
            bits_in_frame_next = Bits15;
          end else begin
            bits_in_frame_next = Bits12;
          end
        end
        if (active_command_next != '0 && phase == PH_IDLE) begin
          shift_word_next         = active_command_next;
          frame_bits_latched_next = bits_in_frame_next;
          phase_next              = PH_START_MARK;
        end
      end
      OP_STOP: active_command_next = '0;
      default: begin
      end
    endcase

    result.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      shift_word         <= '0;
      active_command     <= '0;
      bits_in_frame      <= Bits12;
      frame_bits_latched <= Bits12;
      bit_count          <= '0;
      pause_count        <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      shift_word         <= shift_word_next;
      active_command     <= active_command_next;
      bits_in_frame      <= bits_in_frame_next;
      frame_bits_latched <= frame_bits_latched_next;
      bit_count          <= bit_count_next;
      pause_count        <= pause_count_next;
    end
  end

endmodule

// ===== rtl/sirc_enc_out.sv =====
// Output register stage for result items.
module sirc_enc_out
  import sirc_enc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    load_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      out_result <= result;
    end
  end

endmodule

// ===== rtl/sirc_ir_frame_encoder.sv =====
// Top level of the SIRC infrared frame encoder.
// Takes one item per clock and returns one result item per item, in the cycle
// after acceptance, from a single output register; s_axis_tready drops only
// while that register holds a result that m_axis_tready has not taken. A tick
// item advances the frame by one interval, send/repeat start a frame when idle
// and a command is stored, stop clears the stored command. Config writes
// (cfg_addr 0..4: start mark, one mark, zero mark, space, pause count) take
// effect on the next clock; other addresses are ignored.
module sirc_ir_frame_encoder
  import sirc_enc_pkg::*;
#(
  parameter int unsigned CMD_WIDTH = CmdWidthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CmdInW-1:0]   s_axis_tdata,   // [23:0] command_word
  input  logic [1:0]          s_axis_tuser,   // [1:0] opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] carrier_on, [8:1] interval_len,
                                              // [9] interval_valid, [10] busy_res
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [LenW-1:0]     cfg_wdata
);

  cfg_t    cfg;
  result_t result;
  result_t out_result;
  logic    accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  sirc_enc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sirc_enc_core #(
    .CMD_WIDTH (CMD_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (s_axis_tuser),
    .command_word (s_axis_tdata),
    .cfg          (cfg),
    .result       (result)
  );

  sirc_enc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s_axis_tvalid),
    .result     (result),
    .load_ready (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_result};

endmodule
